// ===== hw/rtl/pattern_literal_block_decoder_assert.svh =====
// Assertion macros for the pattern / literal block decoder.
`ifndef PATTERN_LITERAL_BLOCK_DECODER_ASSERT_SVH
`define PATTERN_LITERAL_BLOCK_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define PLD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLD_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLD_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLD_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/pld_pkg.sv =====
package pld_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] OP_PATTERN   = 8'h65;
    localparam logic [7:0] OP_LITERAL_A = 8'h66;
    localparam logic [7:0] OP_LITERAL_B = 8'h67;
    localparam logic [31:0] PATTERN_TAIL = 32'd5;

    localparam logic [1:0] CFG_EXPECTED_SIZE = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_ENCODED_SIZE  = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_OVER_LIMIT  = 3'd1;
    localparam logic [2:0] ST_OVERFLOW    = 3'd2;
    localparam logic [2:0] ST_BAD_OPCODE  = 3'd3;
    localparam logic [2:0] ST_TRUNC_PAT   = 3'd4;
    localparam logic [2:0] ST_TRUNC_LHDR  = 3'd5;
    localparam logic [2:0] ST_TRUNC_LDATA = 3'd6;
    localparam logic [2:0] ST_MISMATCH    = 3'd7;

    typedef enum logic [2:0] {
        PH_OPCODE = 3'd0,
        PH_PCOUNT = 3'd1,
        PH_PBYTE0 = 3'd2,
        PH_PBYTE1 = 3'd3,
        PH_PBYTE2 = 3'd4,
        PH_PBYTE3 = 3'd5,
        PH_LCOUNT = 3'd6,
        PH_LDATA  = 3'd7
    } t_phase;

    // one queued request: reps copies of word, last one carries status/done
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic [6:0]  reps;
        logic [2:0]  status;
        logic        done;
    } t_cmd;

endpackage

// ===== hw/rtl/pattern_literal_block_decoder.sv =====
// Front decodes one compressed byte per cycle into a request queue of FIFO_DEPTH entries.
// Back emits one result per cycle from its output register while the receiver is ready;
// a pattern block of N words (N up to 64) is one queue entry, emitted N times; the front
// stalls once the queue is full. Results go through the queue, then the output register.
// Reset: synchronous, active low; clears decode, queue and output state; presets registers.
module pattern_literal_block_decoder #(
    parameter int FIFO_DEPTH = pld_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] encoded_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
    output logic [3:0]  m_axis_tuser,   // [2:0] status, [3] stream_done
    output logic        m_axis_tlast    // last_of_run
);

    logic          w_push, w_pop, w_full, w_empty;
    pld_pkg::t_cmd w_in_cmd, w_head;
    logic [31:0]   w_word;
    logic [2:0]    w_cnt, w_status;
    logic          w_done;

    assign o_cfg_ready = 1'b1;

    pld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_byte_valid (s_axis_tvalid),
        .o_byte_ready (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_q_full     (w_full),
        .o_push       (w_push),
        .o_cmd        (w_in_cmd)
    );

    pld_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_in_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    pld_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_head),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data_word   (w_word),
        .o_byte_count  (w_cnt),
        .o_status      (w_status),
        .o_stream_done (w_done),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, w_cnt, w_word};
    assign m_axis_tuser = {w_done, w_status};

`include "pattern_literal_block_decoder_assert.svh"

    `PLD_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
    `PLD_ASSERT(a_done_is_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tlast, "stream end not on last result")
    `PLD_ASSERT(a_empty_is_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[34:32] == 3'd0 |-> m_axis_tuser[3], "empty result without stream end")
    `PLD_ASSERT(a_status_on_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2:0] != 3'd0 |-> m_axis_tuser[3], "error status without stream end")

endmodule

// ===== hw/rtl/pld_front.sv =====
module pld_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_byte_valid,
    output logic          o_byte_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_q_full,
    output logic          o_push,
    output pld_pkg::t_cmd o_cmd
);

    logic [31:0] r_expected;
    logic [31:0] r_limit;
    logic [31:0] r_encoded;

    pld_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_consumed, n_consumed;
    logic [31:0] r_produced, n_produced;
    logic [7:0]  r_repeat, n_repeat;
    logic [23:0] r_pattern, n_pattern;
    logic [7:0]  r_left, n_left;
    logic        r_stopped, n_stopped;

    logic        w_accept;
    logic [31:0] w_inc;
    logic [31:0] w_remaining;
    logic        w_ends;
    logic [8:0]  w_pat_bytes;
    logic [6:0]  w_words;
    logic [8:0]  w_round;
    logic        w_has;
    logic [2:0]  w_end_st;
    pld_pkg::t_cmd w_cmd;

    assign o_byte_ready = !i_q_full;
    assign w_accept     = i_byte_valid && o_byte_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
            r_limit    <= '1;
            r_encoded  <= 32'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pld_pkg::CFG_EXPECTED_SIZE: r_expected <= i_cfg_data;
                pld_pkg::CFG_OUTPUT_LIMIT:  r_limit    <= i_cfg_data;
                pld_pkg::CFG_ENCODED_SIZE:  r_encoded  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_inc       = (r_consumed != '1) ? r_consumed + 32'd1 : r_consumed;
        w_remaining = (r_encoded > w_inc) ? r_encoded - w_inc : '0;
        w_ends      = (w_inc >= r_encoded);
        w_round     = {1'b0, i_byte} + 9'd3;
        w_pat_bytes = {w_round[8:2], 2'b00};
        w_words     = 7'(({1'b0, r_repeat} + 9'd3) >> 2);

        n_phase    = r_phase;
        n_consumed = w_inc;
        n_produced = r_produced;
        n_repeat   = r_repeat;
        n_pattern  = r_pattern;
        n_left     = r_left;
        n_stopped  = r_stopped;
        w_has      = 1'b0;
        w_end_st   = pld_pkg::ST_OK;
        w_cmd.word   = '0;
        w_cmd.cnt    = '0;
        w_cmd.reps   = 7'd1;
        w_cmd.status = pld_pkg::ST_OK;
        w_cmd.done   = 1'b0;

        if (!r_stopped && r_consumed == '0 && r_expected > r_limit) begin
            w_has = 1'b1; w_cmd.status = pld_pkg::ST_OVER_LIMIT; w_cmd.done = 1'b1;
            n_stopped = 1'b1;
        end else if (!r_stopped) begin
            case (r_phase)
                pld_pkg::PH_OPCODE: begin
                    if (i_byte == pld_pkg::OP_PATTERN) begin
                        if (w_remaining < pld_pkg::PATTERN_TAIL) begin
                            w_has = 1'b1; w_cmd.status = pld_pkg::ST_TRUNC_PAT;
                            w_cmd.done = 1'b1; n_stopped = 1'b1;
                        end else begin
                            n_phase = pld_pkg::PH_PCOUNT;
                        end
                    end else if (i_byte == pld_pkg::OP_LITERAL_A ||
                                 i_byte == pld_pkg::OP_LITERAL_B) begin
                        if (w_remaining == '0) begin
                            w_has = 1'b1; w_cmd.status = pld_pkg::ST_TRUNC_LHDR;
                            w_cmd.done = 1'b1; n_stopped = 1'b1;
                        end else begin
                            n_phase = pld_pkg::PH_LCOUNT;
                        end
                    end else begin
                        w_has = 1'b1; w_cmd.status = pld_pkg::ST_BAD_OPCODE;
                        w_cmd.done = 1'b1; n_stopped = 1'b1;
                    end
                end
                pld_pkg::PH_PCOUNT: begin
                    n_repeat = i_byte;
                    if ({1'b0, r_produced} + 33'(w_pat_bytes) > {1'b0, r_expected}) begin
                        w_has = 1'b1; w_cmd.status = pld_pkg::ST_OVERFLOW;
                        w_cmd.done = 1'b1; n_stopped = 1'b1;
                    end else begin
                        n_phase = pld_pkg::PH_PBYTE0;
                    end
                end
                pld_pkg::PH_PBYTE0: begin
                    n_pattern = {16'd0, i_byte};
                    n_phase   = pld_pkg::PH_PBYTE1;
                end
                pld_pkg::PH_PBYTE1: begin
                    n_pattern[15:8] = i_byte;
                    n_phase         = pld_pkg::PH_PBYTE2;
                end
                pld_pkg::PH_PBYTE2: begin
                    n_pattern[23:16] = i_byte;
                    n_phase          = pld_pkg::PH_PBYTE3;
                end
                pld_pkg::PH_PBYTE3: begin
                    if (w_words != '0) begin
                        w_has      = 1'b1;
                        w_cmd.word = {i_byte, r_pattern};
                        w_cmd.cnt  = 3'd4;
                        w_cmd.reps = w_words;
                    end
                    n_produced = r_produced + {23'd0, w_words, 2'b00};
                    n_phase    = pld_pkg::PH_OPCODE;
                end
                pld_pkg::PH_LCOUNT: begin
                    if ({24'd0, i_byte} > w_remaining) begin
                        w_has = 1'b1; w_cmd.status = pld_pkg::ST_TRUNC_LDATA;
                        w_cmd.done = 1'b1; n_stopped = 1'b1;
                    end else if ({1'b0, r_produced} + {25'd0, i_byte} >
                                 {1'b0, r_expected}) begin
                        w_has = 1'b1; w_cmd.status = pld_pkg::ST_OVERFLOW;
                        w_cmd.done = 1'b1; n_stopped = 1'b1;
                    end else begin
                        n_left  = i_byte;
                        n_phase = (i_byte == '0) ? pld_pkg::PH_OPCODE : pld_pkg::PH_LDATA;
                    end
                end
                default: begin
                    w_has      = 1'b1;
                    w_cmd.word = {24'd0, i_byte};
                    w_cmd.cnt  = 3'd1;
                    n_produced = r_produced + 32'd1;
                    n_left     = r_left - 8'd1;
                    if (n_left == '0) begin
                        n_phase = pld_pkg::PH_OPCODE;
                    end
                end
            endcase
        end

        if (w_ends) begin
            if (!n_stopped) begin
                case (n_phase)
                    pld_pkg::PH_LCOUNT: w_end_st = pld_pkg::ST_TRUNC_LHDR;
                    pld_pkg::PH_LDATA:  w_end_st = pld_pkg::ST_TRUNC_LDATA;
                    pld_pkg::PH_OPCODE: w_end_st = (n_produced == r_expected) ?
                                                   pld_pkg::ST_OK : pld_pkg::ST_MISMATCH;
                    default:            w_end_st = pld_pkg::ST_TRUNC_PAT;
                endcase
                w_has        = 1'b1;
                w_cmd.status = w_end_st;
                w_cmd.done   = 1'b1;
            end
            n_phase    = pld_pkg::PH_OPCODE;
            n_consumed = '0;
            n_produced = '0;
            n_repeat   = '0;
            n_pattern  = '0;
            n_left     = '0;
            n_stopped  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= pld_pkg::PH_OPCODE;
            r_consumed <= '0;
            r_produced <= '0;
            r_repeat   <= '0;
            r_pattern  <= '0;
            r_left     <= '0;
            r_stopped  <= 1'b0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_consumed <= n_consumed;
            r_produced <= n_produced;
            r_repeat   <= n_repeat;
            r_pattern  <= n_pattern;
            r_left     <= n_left;
            r_stopped  <= n_stopped;
        end
    end

    assign o_push = w_accept && w_has;
    assign o_cmd  = w_cmd;

endmodule

// ===== hw/rtl/pld_fifo.sv =====
module pld_fifo #(
    parameter int DEPTH = pld_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pld_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output pld_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pld_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_wr, w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/pld_back.sv =====
module pld_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pld_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_data_word,
    output logic [2:0]    o_byte_count,
    output logic [2:0]    o_status,
    output logic          o_stream_done,
    output logic          o_last
);

    logic        r_valid;
    logic [5:0]  r_idx;
    logic [31:0] r_data;
    logic [2:0]  r_cnt;
    logic [2:0]  r_status;
    logic        r_done;
    logic        r_last;
    logic        w_last;
    logic        w_load;

    assign w_last = ({1'b0, r_idx} == i_cmd.reps - 7'd1);
    assign w_load = !i_empty && (!r_valid || i_ready);
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_last ? '0 : r_idx + 6'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data   <= i_cmd.word;
            r_cnt    <= i_cmd.cnt;
            r_status <= w_last ? i_cmd.status : pld_pkg::ST_OK;
            r_done   <= w_last && i_cmd.done;
            r_last   <= w_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_data_word   = r_data;
    assign o_byte_count  = r_cnt;
    assign o_status      = r_status;
    assign o_stream_done = r_done;
    assign o_last        = r_last;

endmodule

// ===== tb/tb_pattern_literal_block_decoder.sv =====
module tb_pattern_literal_block_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import pld_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 65;

    typedef struct packed {
        logic [4:0]  pad;
        logic [2:0]  cnt;
        logic [31:0] word;
        logic [2:0]  status;
        logic        done;
        logic        last;
    } t_word_out;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [31:0] val;
        logic [7:0]  b;
        bit          typed;
        t_word_out   want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_EXPECTED_SIZE;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] encoded_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [31:0] data_word, [34:32] byte_count
    logic [3:0]  m_axis_tuser;        // [2:0] status, [3] stream_done
    logic        m_axis_tlast;

    // decoder copy: registers and stream state
    logic [31:0] reg_expected, reg_limit, reg_encoded;
    t_phase      ph;
    logic [31:0] consumed, produced;
    logic [7:0]  rep_cnt, lit_left;
    logic [23:0] pat_lo;
    bit          halted;

    t_word_out   step_out[$];
    t_word_out   words_due[$];
    t_row        rows[$];
    logic [7:0]  stream_bytes[$];

    int snd_pct = 0;
    int rcv_pct = 0;
    int hold_gen = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;
    int bad_words = 0;
    int words_seen = 0;
    int items_in = 0;
    int streams_run = 0;

    pattern_literal_block_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_word_out mk_word(input logic [31:0] w, input logic [2:0] c,
                                          input logic [2:0] st, input logic d);
        t_word_out r;
        r = '0;
        r.word = w;
        r.cnt = c;
        r.status = st;
        r.done = d;
        return r;
    endfunction

    function void clear_stream();
        ph = PH_OPCODE;
        consumed = '0;
        produced = '0;
        rep_cnt = '0;
        pat_lo = '0;
        lit_left = '0;
        halted = 1'b0;
    endfunction

    function automatic bit room_for(input logic [32:0] add);
        return ({1'b0, produced} + add) <= {1'b0, reg_expected};
    endfunction

    function void stop_with(input logic [2:0] st);
        step_out = {step_out, mk_word('0, 3'd0, st, 1'b1)};
        halted = 1'b1;
    endfunction

    // results of one compressed byte, left in step_out
    function void decode_byte(input logic [7:0] b);
        logic        at_start, at_end;
        logic [31:0] bytes_left;
        logic [2:0]  st;
        int          n;
        t_word_out   tail;
        step_out.delete();
        at_start = (consumed == 0);
        if (consumed != '1) consumed = consumed + 1;
        bytes_left = (reg_encoded > consumed) ? reg_encoded - consumed : '0;
        at_end = (consumed >= reg_encoded);
        if (!halted && at_start && reg_expected > reg_limit) begin
            stop_with(ST_OVER_LIMIT);
        end else if (!halted) begin
            case (ph)
                PH_OPCODE: begin
                    if (b == OP_PATTERN) begin
                        if (bytes_left < PATTERN_TAIL) stop_with(ST_TRUNC_PAT);
                        else ph = PH_PCOUNT;
                    end else if (b == OP_LITERAL_A || b == OP_LITERAL_B) begin
                        if (bytes_left == 0) stop_with(ST_TRUNC_LHDR);
                        else ph = PH_LCOUNT;
                    end else begin
                        stop_with(ST_BAD_OPCODE);
                    end
                end
                PH_PCOUNT: begin
                    rep_cnt = b;
                    if (!room_for(33'((int'(b) + 3) / 4 * 4))) stop_with(ST_OVERFLOW);
                    else ph = PH_PBYTE0;
                end
                PH_PBYTE0: begin
                    pat_lo[7:0] = b;
                    ph = PH_PBYTE1;
                end
                PH_PBYTE1: begin
                    pat_lo[15:8] = b;
                    ph = PH_PBYTE2;
                end
                PH_PBYTE2: begin
                    pat_lo[23:16] = b;
                    ph = PH_PBYTE3;
                end
                PH_PBYTE3: begin
                    n = (int'(rep_cnt) + 3) / 4;
                    repeat (n) step_out = {step_out, mk_word({b, pat_lo}, 3'd4, ST_OK, 1'b0)};
                    produced = produced + 32'(n * 4);
                    ph = PH_OPCODE;
                end
                PH_LCOUNT: begin
                    if (32'(b) > bytes_left) begin
                        stop_with(ST_TRUNC_LDATA);
                    end else if (!room_for(33'(b))) begin
                        stop_with(ST_OVERFLOW);
                    end else begin
                        lit_left = b;
                        ph = (b == 0) ? PH_OPCODE : PH_LDATA;
                    end
                end
                default: begin
                    step_out = {step_out, mk_word(32'(b), 3'd1, ST_OK, 1'b0)};
                    produced = produced + 1;
                    lit_left = lit_left - 8'd1;
                    if (lit_left == 0) ph = PH_OPCODE;
                end
            endcase
        end
        if (at_end) begin
            if (!halted) begin
                if (ph == PH_LCOUNT) st = ST_TRUNC_LHDR;
                else if (ph == PH_LDATA) st = ST_TRUNC_LDATA;
                else if (ph != PH_OPCODE) st = ST_TRUNC_PAT;
                else st = (produced == reg_expected) ? ST_OK : ST_MISMATCH;
                if (step_out.size() == 0) begin
                    step_out = {step_out, mk_word('0, 3'd0, st, 1'b1)};
                end else begin
                    tail = step_out.pop_back();
                    tail.status = st;
                    tail.done = 1'b1;
                    step_out = {step_out, tail};
                end
            end
            clear_stream();
        end
        if (step_out.size() != 0) begin
            tail = step_out.pop_back();
            tail.last = 1'b1;
            step_out = {step_out, tail};
        end
    endfunction

    // receiver: long hold on request, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_seen != hold_gen) begin
            hold_seen <= hold_gen;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_pct);
        end
    end

    always @(posedge i_clk) begin
        t_word_out got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tuser[2:0], m_axis_tuser[3], m_axis_tlast};
            words_seen++;
            if (words_due.size() == 0) begin
                if (bad_words < 10)
                    $display("unexpected result: data %h cnt %0d st %0d done %b last %b",
                             got.word, got.cnt, got.status, got.done, got.last);
                bad_words++;
            end else begin
                want = words_due.pop_front();
                if (got !== want) begin
                    if (bad_words < 10)
                        $display({"mismatch: exp pad %h data %h cnt %0d st %0d done %b ",
                                  "last %b, got pad %h data %h cnt %0d st %0d done %b last %b"},
                                 want.pad, want.word, want.cnt, want.status, want.done,
                                 want.last, got.pad, got.word, got.cnt, got.status,
                                 got.done, got.last);
                    bad_words++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", words_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_EXPECTED_SIZE: reg_expected = val;
            CFG_OUTPUT_LIMIT:  reg_limit = val;
            CFG_ENCODED_SIZE:  reg_encoded = val;
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] exp_sz, input logic [31:0] lim,
                             input logic [31:0] enc);
        s_axis_tvalid <= 1'b0;
        wait_idle();
        write_reg(CFG_EXPECTED_SIZE, exp_sz);
        write_reg(CFG_OUTPUT_LIMIT, lim);
        write_reg(CFG_ENCODED_SIZE, enc);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic feed();
        foreach (stream_bytes[i]) begin
            decode_byte(stream_bytes[i]);
            foreach (step_out[k]) words_due = {words_due, step_out[k]};
            send_byte(stream_bytes[i]);
            items_in++;
        end
        streams_run++;
    endtask

    function void add_cfg(input logic [1:0] idx, input logic [31:0] val);
        t_row r;
        r = '{is_cfg: 1'b1, idx: idx, val: val, b: '0, typed: 1'b0, want: '0};
        rows = {rows, r};
    endfunction

    function void add_byte(input logic [7:0] b);
        t_row r;
        r = '{is_cfg: 1'b0, idx: '0, val: '0, b: b, typed: 1'b0, want: '0};
        rows = {rows, r};
    endfunction

    // byte whose only result is an empty word ending the stream
    function void add_end(input logic [7:0] b, input logic [2:0] st);
        t_row r;
        r = '{is_cfg: 1'b0, idx: '0, val: '0, b: b, typed: 1'b1, want: '0};
        r.want = mk_word('0, 3'd0, st, 1'b1);
        r.want.last = 1'b1;
        rows = {rows, r};
    endfunction

    // random stream: mostly well formed, some cut short, some noise
    task automatic run_stream();
        int          kind, nblk, cnt, len;
        logic [31:0] total, exp_sz, lim;
        logic [7:0]  op;
        stream_bytes.delete();
        total = '0;
        kind = $urandom_range(99);
        if (kind < 90) begin
            nblk = $urandom_range(1, 4);
            repeat (nblk) begin
                if ($urandom_range(1) == 0) begin
                    cnt = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(12);
                    stream_bytes = {stream_bytes, OP_PATTERN};
                    stream_bytes = {stream_bytes, 8'(cnt)};
                    repeat (4) stream_bytes = {stream_bytes, 8'($urandom_range(255))};
                    total = total + 32'((cnt + 3) / 4 * 4);
                end else begin
                    op = ($urandom_range(1) == 0) ? OP_LITERAL_A : OP_LITERAL_B;
                    cnt = $urandom_range(10);
                    stream_bytes = {stream_bytes, op};
                    stream_bytes = {stream_bytes, 8'(cnt)};
                    repeat (cnt) stream_bytes = {stream_bytes, 8'($urandom_range(255))};
                    total = total + 32'(cnt);
                end
            end
            case ($urandom_range(9))
                0: exp_sz = total + $urandom_range(1, 3);
                1: exp_sz = (total != 0) ? total - 1 : total;
                default: exp_sz = total;
            endcase
            case ($urandom_range(9))
                0: lim = (exp_sz != 0) ? exp_sz - 1 : exp_sz;
                1: lim = exp_sz;
                2: lim = exp_sz + $urandom_range(1000);
                default: lim = '1;
            endcase
            if (kind >= 75) begin
                len = $urandom_range(1, stream_bytes.size() - 1);
                while (stream_bytes.size() > len) void'(stream_bytes.pop_back());
            end
        end else begin
            len = $urandom_range(1, 8);
            repeat (len) stream_bytes = {stream_bytes, 8'($urandom_range(255))};
            exp_sz = $urandom();
            lim = $urandom();
        end
        load_regs(exp_sz, lim, 32'(stream_bytes.size()));
        feed();
    endtask

    initial begin
        bit prev_cfg;
        int start_items;
        reg_expected = '0;
        reg_limit = '1;
        reg_encoded = 32'd1;
        clear_stream();
        prev_cfg = 1'b0;

        add_end(8'h00, ST_BAD_OPCODE);
        add_end(OP_PATTERN, ST_TRUNC_PAT);
        add_end(OP_LITERAL_A, ST_TRUNC_LHDR);
        add_cfg(CFG_EXPECTED_SIZE, 32'd5);
        add_cfg(CFG_OUTPUT_LIMIT, 32'd4);
        add_end(8'hFF, ST_OVER_LIMIT);
        add_cfg(CFG_OUTPUT_LIMIT, '1);
        add_cfg(CFG_EXPECTED_SIZE, 32'd256);
        add_cfg(CFG_ENCODED_SIZE, 32'd6);
        add_byte(OP_PATTERN);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_cfg(CFG_EXPECTED_SIZE, 32'd4);
        add_cfg(CFG_ENCODED_SIZE, 32'd2);
        add_byte(OP_LITERAL_A);
        add_end(8'h00, ST_MISMATCH);
        add_byte(OP_LITERAL_B);
        add_end(8'h05, ST_TRUNC_LDATA);
        add_cfg(CFG_EXPECTED_SIZE, 32'd0);
        add_cfg(CFG_ENCODED_SIZE, 32'd3);
        add_byte(OP_LITERAL_A);
        add_end(8'h01, ST_OVERFLOW);
        add_byte(8'h5A);
        // encoded size shortened inside a pattern block, then inside literal data
        add_cfg(CFG_EXPECTED_SIZE, 32'd8);
        add_cfg(CFG_ENCODED_SIZE, 32'd10);
        add_byte(OP_PATTERN);
        add_byte(8'h04);
        add_byte(8'h11);
        add_cfg(CFG_ENCODED_SIZE, 32'd4);
        add_end(8'h22, ST_TRUNC_PAT);
        add_cfg(CFG_ENCODED_SIZE, 32'd10);
        add_byte(OP_LITERAL_A);
        add_byte(8'h03);
        add_byte(8'h41);
        add_cfg(CFG_ENCODED_SIZE, 32'd4);
        add_byte(8'h42);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                if (!prev_cfg) begin
                    s_axis_tvalid <= 1'b0;
                    wait_idle();
                end
                write_reg(rows[i].idx, rows[i].val);
                prev_cfg = 1'b1;
            end else begin
                if (prev_cfg) i_cfg_valid <= 1'b0;
                decode_byte(rows[i].b);
                if (rows[i].typed) words_due = {words_due, rows[i].want};
                else foreach (step_out[k]) words_due = {words_due, step_out[k]};
                send_byte(rows[i].b);
                items_in++;
                prev_cfg = 1'b0;
            end
        end

        // register extremes
        load_regs('1, '1, 32'd4);
        stream_bytes = '{OP_LITERAL_A, 8'h02, 8'h00, 8'hFF};
        feed();
        load_regs('0, '0, 32'd2);
        stream_bytes = '{OP_LITERAL_B, 8'h00};
        feed();
        load_regs(32'd8, 32'd8, '1);
        stream_bytes = '{OP_PATTERN, 8'h05, 8'h01, 8'h02, 8'h04, 8'h08};
        feed();
        load_regs(32'd8, 32'd8, 32'd7);
        stream_bytes = '{OP_LITERAL_A};
        feed();

        for (int m = 0; m < 4; m++) begin
            case (m)
                0: begin snd_pct = 0;  rcv_pct = 0;  end
                1: begin snd_pct = 67; rcv_pct = 0;  end
                2: begin snd_pct = 0;  rcv_pct = 67; end
                default: begin snd_pct = 34; rcv_pct = 34; end
            endcase
            start_items = items_in;
            if (m == 0) begin
                // long receiver hold while a big pattern and literals back up
                load_regs(32'd276, '1, 32'd28);
                stream_bytes = '{OP_PATTERN, 8'hFF};
                repeat (4) stream_bytes = {stream_bytes, 8'($urandom_range(255))};
                stream_bytes = {stream_bytes, OP_LITERAL_B};
                stream_bytes = {stream_bytes, 8'd20};
                repeat (20) stream_bytes = {stream_bytes, 8'($urandom_range(255))};
                hold_gen++;
                feed();
            end
            while (items_in - start_items < PHASE_ITEMS) run_stream();
        end

        s_axis_tvalid <= 1'b0;
        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("Ran %0d streams, %0d compressed bytes, %0d results checked",
                 streams_run, items_in, words_seen);
        $display("Idling: none, sender, receiver, both; one long receiver hold; %0d mismatches",
                 bad_words);
        if (bad_words == 0 && words_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
